// File: sv/text_terminal_byte_interpreter_core_assert.svh
// Assertion macros used by the terminal interpreter checker.
`ifndef TEXT_TERMINAL_BYTE_INTERPRETER_CORE_ASSERT_SVH
`define TEXT_TERMINAL_BYTE_INTERPRETER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define TTBI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ttbi assertion failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define TTBI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ttbi assertion failed");

`endif

// File: sv/ttbi_pkg.sv
// Types, constants and helpers of the text terminal byte interpreter.
`default_nettype none

package ttbi_pkg;

    localparam int GLYPH_WIDTH     = 8;
    localparam int GLYPH_HEIGHT    = 16;
    localparam int BASELINE_OFFSET = 12;
    localparam int TAB_SPACES      = 4;
    localparam int PAYLOAD_LIMIT   = 16;

    localparam int COL_W      = 9;
    localparam int ROW_W      = 7;
    localparam int ROWS_CFG_W = 8;
    localparam int PIX_W      = 11;
    localparam int COLOR_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int TAB_CNT_W  = 3;
    localparam int PAY_CNT_W  = 4;
    localparam int CFG_IDX_W  = 2;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 128;

    localparam logic [COL_W-1:0]      RESET_COLUMNS    = 9'd80;
    localparam logic [ROWS_CFG_W-1:0] RESET_ROWS       = 8'd48;
    localparam logic [COLOR_W-1:0]    RESET_FOREGROUND = 32'h00FF_FFFF;
    localparam logic [COLOR_W-1:0]    RESET_BACKGROUND = 32'h0000_0000;

    // Bytes with meaning to the parser
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_ESC   = 8'h1B;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_SEMI  = 8'h3B;

    localparam logic [CHAR_W-1:0] ESC_CLEAR  = 8'h63;  // 'c'
    localparam logic [CHAR_W-1:0] ESC_FORE   = 8'h66;  // 'f'
    localparam logic [CHAR_W-1:0] ESC_BACK   = 8'h62;  // 'b'
    localparam logic [CHAR_W-1:0] ESC_RESET  = 8'h72;  // 'r'

    typedef enum logic [1:0] {
        CMD_DRAW   = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_SCROLL = 2'd2,
        CMD_ERASE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_NORMAL  = 2'd0,
        PH_COMMAND = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEXT_COLUMNS       = 2'd0,
        REG_TEXT_ROWS          = 2'd1,
        REG_DEFAULT_FOREGROUND = 2'd2,
        REG_DEFAULT_BACKGROUND = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
        logic [COLOR_W-1:0]   fg;
        logic [COLOR_W-1:0]   bg;
        phase_t               phase;
        logic [CHAR_W-1:0]    esc_cmd;
        logic [PAY_CNT_W-1:0] pay_cnt;
        logic [COLOR_W-1:0]   pay_val;
    } term_state_t;

    typedef struct packed {
        cmd_t                command;
        logic [PIX_W-1:0]    pixel_x;
        logic [PIX_W-1:0]    pixel_y;
        logic [CHAR_W-1:0]   glyph;
        logic [COLOR_W-1:0]  fore_color;
        logic [COLOR_W-1:0]  back_color;
        logic                last_of_run;
    } result_t;

    typedef struct packed {
        logic [COL_W-1:0]      columns;
        logic [ROWS_CFG_W-1:0] rows;
        logic [COLOR_W-1:0]    dflt_fg;
        logic [COLOR_W-1:0]    dflt_bg;
    } term_cfg_t;

    function automatic logic [PIX_W-1:0] cell_x(input logic [COL_W-1:0] col);
        return PIX_W'(32'(col) * 32'(GLYPH_WIDTH));
    endfunction

    function automatic logic [PIX_W-1:0] cell_top(input logic [ROW_W-1:0] row);
        return PIX_W'(32'(row) * 32'(GLYPH_HEIGHT));
    endfunction

    function automatic logic [PIX_W-1:0] cell_base(input logic [ROW_W-1:0] row);
        return PIX_W'(32'(row) * 32'(GLYPH_HEIGHT) + 32'(BASELINE_OFFSET));
    endfunction

endpackage

`default_nettype wire

// File: sv/text_terminal_byte_interpreter_core.sv
// Text terminal byte interpreter: one byte in, a run of display commands out.
// Each accepted byte is held in an item register and worked off by a step unit
// that issues at most one command per cycle into the result register. A byte
// making no command (NUL, CR, escape and payload bytes, color changes) does not
// wait on the result register; a printable byte draws once, after a scroll
// when a deferred wrap at the bottom row comes first, and a tab four times. With
// m_ready held high a new byte is accepted in the cycle its predecessor's last
// command is issued, so plain text streams at one byte per cycle. Configuration
// takes effect on the next step; no clearing pass.
`default_nettype none

module text_terminal_byte_interpreter_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ttbi_pkg::CHAR_W-1:0]         s_byte_in,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [1:0]                               m_command,
    output logic [ttbi_pkg::PIX_W-1:0]               m_pixel_x,
    output logic [ttbi_pkg::PIX_W-1:0]               m_pixel_y,
    output logic [ttbi_pkg::CHAR_W-1:0]              m_glyph,
    output logic [ttbi_pkg::COLOR_W-1:0]             m_fore_color,
    output logic [ttbi_pkg::COLOR_W-1:0]             m_back_color,
    output logic                                     m_last_of_run,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ttbi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ttbi_pkg::COLOR_W-1:0]        cfg_wdata
);

    ttbi_pkg::term_cfg_t   cfg_reg;
    ttbi_pkg::term_state_t state_reg;
    ttbi_pkg::term_state_t state_next;
    ttbi_pkg::result_t     result_reg;
    ttbi_pkg::result_t     result_next;

    logic                               item_valid_reg;
    logic [ttbi_pkg::CHAR_W-1:0]        item_byte_reg;
    logic [ttbi_pkg::TAB_CNT_W-1:0]     tab_left_reg;
    logic [ttbi_pkg::TAB_CNT_W-1:0]     tab_left_next;
    logic                               m_valid_reg;

    logic step_emit;
    logic step_done;
    logic out_free;
    logic fire;
    logic item_last;
    logic s_take;

    ttbi_step u_step (
        .cur           (state_reg),
        .cfg           (cfg_reg),
        .byte_in       (item_byte_reg),
        .tab_left      (tab_left_reg),
        .nxt           (state_next),
        .res           (result_next),
        .emit          (step_emit),
        .done          (step_done),
        .tab_left_next (tab_left_next)
    );

    assign out_free  = !m_valid_reg || m_ready;
    // a step with no command does not wait on the result register
    assign fire      = item_valid_reg && (!step_emit || out_free);
    assign item_last = fire && step_done;
    assign s_ready   = !item_valid_reg || item_last;
    assign s_take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.columns <= ttbi_pkg::RESET_COLUMNS;
            cfg_reg.rows    <= ttbi_pkg::RESET_ROWS;
            cfg_reg.dflt_fg <= ttbi_pkg::RESET_FOREGROUND;
            cfg_reg.dflt_bg <= ttbi_pkg::RESET_BACKGROUND;
            state_reg.col     <= '0;
            state_reg.row     <= '0;
            state_reg.fg      <= ttbi_pkg::RESET_FOREGROUND;
            state_reg.bg      <= ttbi_pkg::RESET_BACKGROUND;
            state_reg.phase   <= ttbi_pkg::PH_NORMAL;
            state_reg.esc_cmd <= '0;
            state_reg.pay_cnt <= '0;
            state_reg.pay_val <= '0;
            item_valid_reg <= 1'b0;
            tab_left_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    ttbi_pkg::REG_TEXT_COLUMNS:
                        cfg_reg.columns <= cfg_wdata[ttbi_pkg::COL_W-1:0];
                    ttbi_pkg::REG_TEXT_ROWS:
                        cfg_reg.rows <= cfg_wdata[ttbi_pkg::ROWS_CFG_W-1:0];
                    ttbi_pkg::REG_DEFAULT_FOREGROUND:
                        cfg_reg.dflt_fg <= cfg_wdata;
                    ttbi_pkg::REG_DEFAULT_BACKGROUND:
                        cfg_reg.dflt_bg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (fire) begin
                state_reg <= state_next;
            end
            if (s_take) begin
                item_valid_reg <= 1'b1;
                tab_left_reg   <= ttbi_pkg::TAB_CNT_W'(ttbi_pkg::TAB_SPACES);
            end else begin
                if (item_last) begin
                    item_valid_reg <= 1'b0;
                end
                if (fire) begin
                    tab_left_reg <= tab_left_next;
                end
            end
            if (out_free) begin
                m_valid_reg <= fire && step_emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_byte_reg <= s_byte_in;
        end
        if (out_free && fire && step_emit) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_command     = result_reg.command;
    assign m_pixel_x     = result_reg.pixel_x;
    assign m_pixel_y     = result_reg.pixel_y;
    assign m_glyph       = result_reg.glyph;
    assign m_fore_color  = result_reg.fore_color;
    assign m_back_color  = result_reg.back_color;
    assign m_last_of_run = result_reg.last_of_run;

endmodule

`default_nettype wire

// File: sv/ttbi_step.sv
// One step of the interpreter: next terminal state and at most one command.
`default_nettype none

module ttbi_step (
    input  var ttbi_pkg::term_state_t                 cur,
    input  var ttbi_pkg::term_cfg_t                   cfg,
    input  wire logic [ttbi_pkg::CHAR_W-1:0]          byte_in,
    input  wire logic [ttbi_pkg::TAB_CNT_W-1:0]       tab_left,
    output ttbi_pkg::term_state_t                     nxt,
    output ttbi_pkg::result_t                         res,
    output logic                                      emit,
    output logic                                      done,
    output logic [ttbi_pkg::TAB_CNT_W-1:0]            tab_left_next
);

    logic [ttbi_pkg::COL_W-1:0]      cols_eff;
    logic [ttbi_pkg::ROWS_CFG_W-1:0] rows_eff;
    logic [ttbi_pkg::ROWS_CFG_W-1:0] row_inc;
    logic [ttbi_pkg::ROWS_CFG_W-1:0] lf_row;
    logic                            lf_scroll;
    logic                            wrap;
    logic [ttbi_pkg::COL_W-1:0]      draw_col;
    logic [ttbi_pkg::ROW_W-1:0]      draw_row;
    logic [ttbi_pkg::CHAR_W-1:0]     glyph_code;
    logic                            is_hex;
    logic [3:0]                      hex_digit;

    always_comb begin
        if (cfg.columns == '0) begin
            cols_eff = ttbi_pkg::COL_W'(1);
        end else if (cfg.columns > ttbi_pkg::COL_W'(ttbi_pkg::MAX_COLUMNS)) begin
            cols_eff = ttbi_pkg::COL_W'(ttbi_pkg::MAX_COLUMNS);
        end else begin
            cols_eff = cfg.columns;
        end
        if (cfg.rows == '0) begin
            rows_eff = ttbi_pkg::ROWS_CFG_W'(1);
        end else if (cfg.rows > ttbi_pkg::ROWS_CFG_W'(ttbi_pkg::MAX_ROWS)) begin
            rows_eff = ttbi_pkg::ROWS_CFG_W'(ttbi_pkg::MAX_ROWS);
        end else begin
            rows_eff = cfg.rows;
        end
    end

    // Line feed target; a cursor below a shrunken screen lands on the last row
    assign row_inc   = {1'b0, cur.row} + ttbi_pkg::ROWS_CFG_W'(1);
    assign lf_scroll = row_inc >= rows_eff;
    assign lf_row    = lf_scroll ? (rows_eff - ttbi_pkg::ROWS_CFG_W'(1)) : row_inc;
    assign wrap      = cur.col >= cols_eff;
    assign draw_col  = wrap ? '0 : cur.col;
    assign draw_row  = wrap ? lf_row[ttbi_pkg::ROW_W-1:0] : cur.row;
    assign glyph_code = (byte_in == ttbi_pkg::CHAR_TAB) ? ttbi_pkg::CHAR_SPACE : byte_in;

    always_comb begin
        is_hex    = 1'b1;
        hex_digit = '0;
        if (byte_in >= 8'h30 && byte_in <= 8'h39) begin
            hex_digit = 4'(byte_in - 8'h30);
        end else if (byte_in >= 8'h61 && byte_in <= 8'h66) begin
            hex_digit = 4'(byte_in - 8'h57);
        end else if (byte_in >= 8'h41 && byte_in <= 8'h46) begin
            hex_digit = 4'(byte_in - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
    end

    always_comb begin
        nxt           = cur;
        emit          = 1'b0;
        done          = 1'b1;
        tab_left_next = tab_left;
        res           = '0;
        res.command   = ttbi_pkg::CMD_DRAW;

        unique case (cur.phase)
            ttbi_pkg::PH_COMMAND: begin
                nxt.esc_cmd = byte_in;
                nxt.pay_cnt = '0;
                nxt.pay_val = '0;
                nxt.phase   = ttbi_pkg::PH_PAYLOAD;
            end
            ttbi_pkg::PH_PAYLOAD: begin
                if (byte_in == ttbi_pkg::CHAR_SEMI) begin
                    nxt.phase = ttbi_pkg::PH_NORMAL;
                    unique case (cur.esc_cmd)
                        ttbi_pkg::ESC_CLEAR: begin
                            emit        = 1'b1;
                            res.command = ttbi_pkg::CMD_FILL;
                            nxt.col     = '0;
                            nxt.row     = '0;
                        end
                        ttbi_pkg::ESC_FORE: begin
                            nxt.fg = cur.pay_val;
                        end
                        ttbi_pkg::ESC_BACK: begin
                            nxt.bg      = cur.pay_val;
                            emit        = 1'b1;
                            res.command = ttbi_pkg::CMD_FILL;
                            nxt.col     = '0;
                            nxt.row     = '0;
                        end
                        ttbi_pkg::ESC_RESET: begin
                            nxt.fg = cfg.dflt_fg;
                            nxt.bg = cfg.dflt_bg;
                        end
                        default: begin
                        end
                    endcase
                end else if (cur.pay_cnt < ttbi_pkg::PAY_CNT_W'(ttbi_pkg::PAYLOAD_LIMIT - 1)) begin
                    nxt.pay_cnt = cur.pay_cnt + ttbi_pkg::PAY_CNT_W'(1);
                    if (is_hex) begin
                        nxt.pay_val = {cur.pay_val[ttbi_pkg::COLOR_W-5:0], hex_digit};
                    end
                end
            end
            default: begin
                if (byte_in == ttbi_pkg::CHAR_ESC) begin
                    nxt.phase = ttbi_pkg::PH_COMMAND;
                end else begin
                    nxt.phase = ttbi_pkg::PH_NORMAL;
                    unique case (byte_in)
                        ttbi_pkg::CHAR_NUL: begin
                        end
                        ttbi_pkg::CHAR_LF: begin
                            nxt.col = '0;
                            nxt.row = lf_row[ttbi_pkg::ROW_W-1:0];
                            if (lf_scroll) begin
                                emit        = 1'b1;
                                res.command = ttbi_pkg::CMD_SCROLL;
                            end
                        end
                        ttbi_pkg::CHAR_CR: begin
                            nxt.col = '0;
                        end
                        ttbi_pkg::CHAR_BS: begin
                            if (cur.col == '0) begin
                                if (cur.row != '0) begin
                                    nxt.row = cur.row - ttbi_pkg::ROW_W'(1);
                                    nxt.col = cols_eff - ttbi_pkg::COL_W'(1);
                                    emit    = 1'b1;
                                end
                            end else begin
                                nxt.col = cur.col - ttbi_pkg::COL_W'(1);
                                emit    = 1'b1;
                            end
                            res.command = ttbi_pkg::CMD_ERASE;
                            res.pixel_x = ttbi_pkg::cell_x(nxt.col);
                            res.pixel_y = ttbi_pkg::cell_top(nxt.row);
                        end
                        ttbi_pkg::CHAR_FF: begin
                            emit        = 1'b1;
                            res.command = ttbi_pkg::CMD_FILL;
                            nxt.col     = '0;
                            nxt.row     = '0;
                        end
                        default: begin
                            emit = 1'b1;
                            if (wrap && lf_scroll) begin
                                // deferred wrap at the bottom: scroll now, draw next step
                                res.command = ttbi_pkg::CMD_SCROLL;
                                nxt.col     = '0;
                                nxt.row     = lf_row[ttbi_pkg::ROW_W-1:0];
                                done        = 1'b0;
                            end else begin
                                res.command = ttbi_pkg::CMD_DRAW;
                                res.pixel_x = ttbi_pkg::cell_x(draw_col);
                                res.pixel_y = ttbi_pkg::cell_base(draw_row);
                                res.glyph   = glyph_code;
                                nxt.col     = draw_col + ttbi_pkg::COL_W'(1);
                                nxt.row     = draw_row;
                                if (byte_in == ttbi_pkg::CHAR_TAB) begin
                                    tab_left_next = tab_left - ttbi_pkg::TAB_CNT_W'(1);
                                    done = (tab_left == ttbi_pkg::TAB_CNT_W'(1));
                                end
                            end
                        end
                    endcase
                end
            end
        endcase

        res.fore_color  = nxt.fg;
        res.back_color  = nxt.bg;
        res.last_of_run = done;
    end

endmodule

`default_nettype wire

// File: sv/ttbi_checker.sv
// Port-level checker for the terminal interpreter, bound to the top level.
`default_nettype none

`include "text_terminal_byte_interpreter_core_assert.svh"

module ttbi_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic [ttbi_pkg::CHAR_W-1:0]        s_byte_in,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic [1:0]                         m_command,
    input wire logic [ttbi_pkg::PIX_W-1:0]         m_pixel_x,
    input wire logic [ttbi_pkg::PIX_W-1:0]         m_pixel_y,
    input wire logic [ttbi_pkg::CHAR_W-1:0]        m_glyph,
    input wire logic [ttbi_pkg::COLOR_W-1:0]       m_fore_color,
    input wire logic [ttbi_pkg::COLOR_W-1:0]       m_back_color,
    input wire logic                               m_last_of_run
);

    logic [$bits(ttbi_pkg::result_t)-1:0] m_payload;
    logic                                 is_fill;
    logic                                 is_scroll;
    logic                                 is_erase;
    logic                                 no_place;

    assign m_payload = {m_command, m_pixel_x, m_pixel_y, m_glyph,
                        m_fore_color, m_back_color, m_last_of_run};
    assign is_fill   = m_valid && (m_command == ttbi_pkg::CMD_FILL);
    assign is_scroll = m_valid && (m_command == ttbi_pkg::CMD_SCROLL);
    assign is_erase  = m_valid && (m_command == ttbi_pkg::CMD_ERASE);
    assign no_place  = (m_pixel_x == '0) && (m_pixel_y == '0) && (m_glyph == '0);

    // a waiting byte keeps its value
    `TTBI_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_byte_in))

    // a stalled item holds its whole payload
    `TTBI_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_payload))

    // fills always end their run and carry no position or glyph
    `TTBI_ASSERT_IMPL(a_fill_shape, is_fill, m_last_of_run && no_place)

    `TTBI_ASSERT_IMPL(a_scroll_shape, is_scroll, no_place)

    // backspace erases exactly one cell
    `TTBI_ASSERT_IMPL(a_erase_shape, is_erase, m_last_of_run && m_glyph == '0)

endmodule

bind text_terminal_byte_interpreter_core ttbi_checker u_ttbi_checker (.*);

`default_nettype wire
